### src/sthc_pkg.sv
`default_nettype none
package sthc_pkg;

  localparam int unsigned PosBits = 16;
  localparam int unsigned AdcBits = 10;
  localparam int unsigned CfgBits = 16;
  localparam int unsigned CmdBits = 2;
  localparam int unsigned ModeBits = 2;

  localparam int unsigned InDataBits = 32;
  localparam int unsigned OutDataBits = 24;

  // Command codes carried in the input tuser
  localparam logic [CmdBits-1:0] CMD_TICK = 2'd0;
  localparam logic [CmdBits-1:0] CMD_MOVE = 2'd1;
  localparam logic [CmdBits-1:0] CMD_RECAL = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
  localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_LIMIT_THRESHOLD = 2'd2;

  // Mode codes as reported on the result
  localparam logic [ModeBits-1:0] MODE_CODE_CAL = 2'd0;
  localparam logic [ModeBits-1:0] MODE_CODE_MOVE = 2'd1;
  localparam logic [ModeBits-1:0] MODE_CODE_DONE = 2'd2;

  localparam logic [CfgBits-1:0] STEP_INTERVAL_RST = 16'd1;
  localparam logic [CfgBits-1:0] LOCKOUT_TICKS_RST = 16'd200;
  localparam logic [AdcBits-1:0] LIMIT_THRESHOLD_RST = 10'd100;

  localparam logic [PosBits-1:0] POS_MAX = {PosBits{1'b1}};

  typedef enum logic [2:0] {
    MODE_CAL  = 3'b001,
    MODE_MOVE = 3'b010,
    MODE_DONE = 3'b100
  } mode_t;

  typedef struct packed {
    logic               move_rejected;
    logic [PosBits-1:0] position;
    logic [ModeBits-1:0] mode;
    logic               step_forward;
    logic               step_pulse;
  } result_t;

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    sat_inc = (v == POS_MAX) ? POS_MAX : v + 1'b1;
  endfunction

  function automatic logic [ModeBits-1:0] mode_code(input mode_t m);
    unique case (m)
      MODE_CAL:  mode_code = MODE_CODE_CAL;
      MODE_MOVE: mode_code = MODE_CODE_MOVE;
      MODE_DONE: mode_code = MODE_CODE_DONE;
      default:   mode_code = MODE_CODE_CAL;
    endcase
  endfunction

endpackage
`default_nettype wire

### src/stepper_traverse_homing_controller.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: target, limit_level
// m_*       out  m_tvalid/m_tready  tdata: step_pulse, step_forward, mode, position,
//                                   move_rejected
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data is the value
//
// One beat per clock while s_tready is high. The controller state and result are
// computed from the accepted beat in one pass and registered in the output register,
// or in the skid register behind it while the output is stalled, so one more beat
// is taken while m_tready is low; s_tready drops only once both registers are full.
// rst (synchronous) restores the registers and the calibrating state.
module stepper_traverse_homing_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] target, [25:16] limit_level, [31:26] zero
  input  wire logic [sthc_pkg::InDataBits-1:0]   s_tdata,
  // [1:0] cmd
  input  wire logic [sthc_pkg::CmdBits-1:0]      s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] step_pulse, [1] step_forward, [3:2] mode, [19:4] position,
  // [20] move_rejected, [23:21] zero
  output logic [sthc_pkg::OutDataBits-1:0]       m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [sthc_pkg::CfgBits-1:0]      cfg_data
);
  import sthc_pkg::*;

  // Configuration
  logic [CfgBits-1:0] step_interval;
  logic [CfgBits-1:0] lockout_ticks;
  logic [AdcBits-1:0] limit_threshold;

  // Controller state
  mode_t              mode_reg, mode_reg_next;
  logic               moving_forward, moving_forward_next;
  logic               edge_found, edge_found_next;
  logic [PosBits-1:0] position_reg, position_reg_next;
  logic [PosBits-1:0] target_position, target_position_next;
  logic [PosBits-1:0] travel_length, travel_length_next;
  logic [CfgBits-1:0] step_wait, step_wait_next;
  logic [CfgBits-1:0] lockout_wait, lockout_wait_next;
  logic               lockout_active, lockout_active_next;

  // Output register and skid register
  result_t out_res, skid_res, res_next;
  logic    out_valid, skid_valid;

  logic [CmdBits-1:0] cmd;
  logic [PosBits-1:0] target;
  logic [AdcBits-1:0] limit_level;
  logic               accept, pop;
  logic               lock_mid, hit;
  logic               pulse, fwd, rejected;
  logic [PosBits-1:0] travel_inc;

  assign cmd         = s_tuser;
  assign target      = s_tdata[PosBits-1:0];
  assign limit_level = s_tdata[PosBits +: AdcBits];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataBits - $bits(result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval   <= STEP_INTERVAL_RST;
      lockout_ticks   <= LOCKOUT_TICKS_RST;
      limit_threshold <= LIMIT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_INTERVAL:   step_interval   <= cfg_data;
        REG_LOCKOUT_TICKS:   lockout_ticks   <= cfg_data;
        REG_LIMIT_THRESHOLD: limit_threshold <= cfg_data[AdcBits-1:0];
        default: ;  // no register here, drop the write
      endcase
    end
  end

  // One pass over the accepted beat
  always_comb begin
    mode_reg_next        = mode_reg;
    moving_forward_next  = moving_forward;
    edge_found_next      = edge_found;
    position_reg_next    = position_reg;
    target_position_next = target_position;
    travel_length_next   = travel_length;
    step_wait_next       = step_wait;
    lockout_wait_next    = lockout_wait;
    lockout_active_next  = lockout_active;
    pulse                = 1'b0;
    fwd                  = 1'b0;
    rejected             = 1'b0;
    lock_mid             = lockout_active;
    hit                  = 1'b0;
    travel_inc           = sat_inc(travel_length);

    unique case (cmd)
      CMD_TICK: begin
        // Age the lockout before the switch is looked at on this tick
        if (lockout_active) begin
          if (lockout_wait >= lockout_ticks) begin
            lock_mid = 1'b0;
          end else begin
            lockout_wait_next = lockout_wait + 1'b1;
          end
        end
        lockout_active_next = lock_mid;

        if (step_wait >= step_interval) begin
          step_wait_next = '0;
          unique case (mode_reg)
            MODE_CAL: begin
              pulse = 1'b1;
              fwd   = moving_forward;
              if (edge_found) begin
                travel_length_next = travel_inc;
                position_reg_next  = sat_inc(position_reg);
              end
              hit = (limit_level > limit_threshold) && !lock_mid;
              if (hit) begin
                lockout_active_next = 1'b1;
                lockout_wait_next   = '0;
                if (edge_found) begin
                  // Second edge: travel is measured, head for mid-travel
                  mode_reg_next        = MODE_MOVE;
                  target_position_next = travel_inc >> 1;
                end
                edge_found_next     = 1'b1;
                moving_forward_next = !moving_forward;
              end
            end
            MODE_MOVE: begin
              if (target_position == position_reg) begin
                mode_reg_next = MODE_DONE;
              end else if (target_position > position_reg) begin
                pulse             = 1'b1;
                fwd               = 1'b1;
                position_reg_next = sat_inc(position_reg);
              end else begin
                pulse             = 1'b1;
                position_reg_next = position_reg - 1'b1;
              end
            end
            MODE_DONE: ;
            default: ;
          endcase
        end else begin
          step_wait_next = step_wait + 1'b1;
        end
      end
      CMD_MOVE: begin
        if (mode_reg != MODE_CAL && travel_length != '0 && target <= travel_length) begin
          target_position_next = target;
          mode_reg_next        = MODE_MOVE;
        end else begin
          rejected = 1'b1;
        end
      end
      CMD_RECAL: begin
        mode_reg_next       = MODE_CAL;
        moving_forward_next = 1'b0;
        edge_found_next     = 1'b0;
        position_reg_next   = '0;
        travel_length_next  = '0;
      end
      default: ;  // unused command, no effect
    endcase

    res_next.step_pulse    = pulse;
    res_next.step_forward  = fwd;
    res_next.mode          = mode_code(mode_reg_next);
    res_next.position      = position_reg_next;
    res_next.move_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_CAL;
      moving_forward  <= 1'b0;
      edge_found      <= 1'b0;
      position_reg    <= '0;
      target_position <= '0;
      travel_length   <= '0;
      step_wait       <= '0;
      lockout_wait    <= '0;
      lockout_active  <= 1'b0;
    end else if (accept) begin
      mode_reg        <= mode_reg_next;
      moving_forward  <= moving_forward_next;
      edge_found      <= edge_found_next;
      position_reg    <= position_reg_next;
      target_position <= target_position_next;
      travel_length   <= travel_length_next;
      step_wait       <= step_wait_next;
      lockout_wait    <= lockout_wait_next;
      lockout_active  <= lockout_active_next;
    end
  end

  // Output register with skid: hold a result in skid while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_res <= res_next;
      end else begin
        skid_res <= res_next;
      end
    end
  end

endmodule
`default_nettype wire
